FILE: hw/rtl/utu_pkg.sv
package utu_pkg;

    // format codes shared by both configuration registers
    localparam logic [1:0] FmtUtf8 = 2'd0;
    localparam logic [1:0] FmtLe   = 2'd1;
    localparam logic [1:0] FmtBe   = 2'd2;
    localparam logic [1:0] FmtBad  = 2'd3;

    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 2;
    localparam logic [CfgIdxW-1:0] CfgSrcIdx = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgTgtIdx = 2'd1;

    localparam int QueueDepth = 2;
    localparam int CodeW      = 21;

    typedef enum logic [2:0] {
        KindErr,
        KindRaw1,
        KindRaw2,
        KindCode,
        KindErrCode
    } t_kind;

    // one classified input byte, handed from the front to the back
    typedef struct packed {
        t_kind              kind;
        logic               big_end;
        logic [CodeW-1:0]   code;
        logic [7:0]         b0;
        logic [7:0]         b1;
    } t_job;

endpackage

FILE: hw/rtl/utu_front.sv
module utu_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [utu_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [utu_pkg::CfgDatW-1:0]   i_cfg_data,
    input  logic                          i_full,
    output logic                          o_push,
    output utu_pkg::t_job                 o_job
);

    logic [1:0]                 r_src, r_tgt;
    logic [1:0]                 r_pend, n_pend;
    logic [utu_pkg::CodeW-1:0]  r_acc, n_acc;
    logic [7:0]                 r_held, n_held;
    logic                       r_held_vld, n_held_vld;

    logic                       accept, push;
    logic [utu_pkg::CodeW-1:0]  acc_ext, lead_acc;
    logic [1:0]                 lead_pend;
    logic                       is_ascii, lead_multi;
    utu_pkg::t_job              job;

    assign o_in_ready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign o_push      = accept && push;
    assign o_job       = job;

    assign acc_ext  = {r_acc[14:0], i_in_byte[5:0]};
    assign is_ascii = !i_in_byte[7];

    // lead byte classification
    always_comb begin
        lead_multi = 1'b1;
        lead_acc   = '0;
        lead_pend  = 2'd0;
        if (i_in_byte[7:5] == 3'b110) begin
            lead_acc  = {16'd0, i_in_byte[4:0]};
            lead_pend = 2'd1;
        end else if (i_in_byte[7:4] == 4'b1110) begin
            lead_acc  = {17'd0, i_in_byte[3:0]};
            lead_pend = 2'd2;
        end else if (i_in_byte[7:3] == 5'b11110) begin
            lead_acc  = {18'd0, i_in_byte[2:0]};
            lead_pend = 2'd3;
        end else begin
            lead_multi = 1'b0;
        end
    end

    always_comb begin
        n_pend     = r_pend;
        n_acc      = r_acc;
        n_held     = r_held;
        n_held_vld = r_held_vld;
        push       = 1'b0;
        job        = '0;
        job.kind   = utu_pkg::KindErr;
        job.big_end = (r_tgt == utu_pkg::FmtBe);
        job.b0     = i_in_byte;
        job.b1     = r_held;
        job.code   = utu_pkg::CodeW'(i_in_byte);
        if (r_src == utu_pkg::FmtBad || r_tgt == utu_pkg::FmtBad) begin
            push = 1'b1;
        end else if (r_src == r_tgt) begin
            push     = 1'b1;
            job.kind = utu_pkg::KindRaw1;
        end else if (r_src == utu_pkg::FmtUtf8) begin
            if (r_pend == 2'd0) begin
                if (is_ascii) begin
                    push     = 1'b1;
                    job.kind = utu_pkg::KindCode;
                end else if (lead_multi) begin
                    n_acc  = lead_acc;
                    n_pend = lead_pend;
                end else begin
                    push = 1'b1;
                end
            end else if (i_in_byte[7:6] == 2'b10) begin
                n_acc  = acc_ext;
                n_pend = r_pend - 2'd1;
                if (r_pend == 2'd1) begin
                    push     = 1'b1;
                    job.kind = utu_pkg::KindCode;
                    job.code = acc_ext;
                    n_acc    = '0;
                end
            end else begin
                // broken sequence: report, then restart on this byte
                push   = 1'b1;
                n_pend = lead_multi ? lead_pend : 2'd0;
                n_acc  = lead_multi ? lead_acc : '0;
                if (is_ascii) begin
                    job.kind = utu_pkg::KindErrCode;
                end
            end
        end else if (r_tgt != utu_pkg::FmtUtf8) begin
            if (!r_held_vld) begin
                n_held     = i_in_byte;
                n_held_vld = 1'b1;
            end else begin
                push       = 1'b1;
                job.kind   = utu_pkg::KindRaw2;
                n_held     = '0;
                n_held_vld = 1'b0;
            end
        end else begin
            push = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src      <= utu_pkg::FmtUtf8;
            r_tgt      <= utu_pkg::FmtLe;
            r_pend     <= 2'd0;
            r_acc      <= '0;
            r_held     <= '0;
            r_held_vld <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    utu_pkg::CfgSrcIdx: r_src <= i_cfg_data;
                    utu_pkg::CfgTgtIdx: r_tgt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_pend     <= n_pend;
                r_acc      <= n_acc;
                r_held     <= n_held;
                r_held_vld <= n_held_vld;
            end
        end
    end

endmodule

FILE: hw/rtl/utu_fifo.sv
module utu_fifo #(
    parameter int DEPTH = utu_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utu_pkg::t_job   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_nempty,
    output utu_pkg::t_job   o_data
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    utu_pkg::t_job      r_mem [DEPTH];
    logic [PtrW-1:0]    r_wp, r_rp;
    logic [CntW-1:0]    r_cnt;

    assign o_full   = (r_cnt == CntW'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PtrW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PtrW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/utu_back.sv
module utu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_vld,
    input  utu_pkg::t_job   i_job,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_bad_input
);

    logic [7:0]     r_q [4];
    logic [7:0]     n_q [4];
    logic [2:0]     r_cnt, n_cnt;
    logic           r_bad, n_bad;
    logic           r_busy;
    logic           r_out_vld, r_out_last, r_out_bad;
    logic [7:0]     r_out_byte;
    logic           out_load;

    logic [utu_pkg::CodeW-1:0]  w;
    logic [15:0]    hi_u, lo_u, ord0, ord1;
    logic           bmp;

    // byte order of one code unit: first byte in [15:8]
    function automatic logic [15:0] order_unit(input logic [15:0] u, input logic be);
        order_unit = be ? u : {u[7:0], u[15:8]};
    endfunction

    assign w    = i_job.code - utu_pkg::CodeW'(21'h10000);
    assign hi_u = 16'hD800 + {5'd0, w[20:10]};
    assign lo_u = {6'b110111, w[9:0]};
    assign bmp  = (i_job.code[20:16] == 5'd0);
    assign ord0 = order_unit(bmp ? i_job.code[15:0] : hi_u, i_job.big_end);
    assign ord1 = order_unit(lo_u, i_job.big_end);

    always_comb begin
        n_q[0] = 8'd0;
        n_q[1] = 8'd0;
        n_q[2] = 8'd0;
        n_q[3] = 8'd0;
        n_cnt  = 3'd1;
        n_bad  = 1'b0;
        case (i_job.kind)
            utu_pkg::KindRaw1: begin
                n_q[0] = i_job.b0;
            end
            utu_pkg::KindRaw2: begin
                n_q[0] = i_job.b0;
                n_q[1] = i_job.b1;
                n_cnt  = 3'd2;
            end
            utu_pkg::KindCode: begin
                n_q[0] = ord0[15:8];
                n_q[1] = ord0[7:0];
                n_q[2] = ord1[15:8];
                n_q[3] = ord1[7:0];
                n_cnt  = bmp ? 3'd2 : 3'd4;
            end
            utu_pkg::KindErrCode: begin
                n_q[1] = ord0[15:8];
                n_q[2] = ord0[7:0];
                n_cnt  = 3'd3;
                n_bad  = 1'b1;
            end
            default: begin
                n_bad = 1'b1;
            end
        endcase
    end

    assign out_load = r_busy && (!r_out_vld || i_out_ready);
    assign o_pop    = i_job_vld && (!r_busy || (out_load && r_cnt == 3'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= 3'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= n_cnt;
            end else if (out_load) begin
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte <= r_q[0];
            r_out_last <= (r_cnt == 3'd1);
            r_out_bad  <= r_bad;
        end
        if (o_pop) begin
            r_q   <= n_q;
            r_bad <= n_bad;
        end else if (out_load) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
            r_q[2] <= r_q[3];
            r_q[3] <= 8'd0;
            r_bad  <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_bad_input   = r_out_bad;

endmodule

FILE: hw/rtl/utf8_to_utf16_transcoder.sv
// byte-serial transcoder: utf-8 to utf-16le/be, utf-16 byte swap, or copy
// input channel: i_in_valid / o_in_ready with i_in_byte, one byte per transfer
// output channel: o_out_valid / i_out_ready, one result byte per transfer;
//   o_last_of_run marks the last result caused by an input byte, o_bad_input
//   marks an error result (byte zero)
// config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index 0 is
//   the source format, 1 the target format; write only while the block is idle
// the front decodes each byte and queues a job (QUEUE_DEPTH entries); the back
//   expands a job into 1 to 4 result bytes, one per cycle, into an output register
// each job is registered in the queue, then in the back's byte register, and
//   each result byte in the output register
// throughput: one result byte per cycle while the receiver is ready; ascii yields
//   two, a surrogate pair four; a byte that yields nothing takes no queue entry
// when the receiver stalls the output register holds, the queue fills and
//   o_in_ready drops once it is full
// reset clears the decode state, the queue and the output register; formats
//   return to utf-8 source and utf-16le target
module utf8_to_utf16_transcoder #(
    parameter int QUEUE_DEPTH = utu_pkg::QueueDepth
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_in_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last_of_run,
    output logic                          o_bad_input,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [utu_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [utu_pkg::CfgDatW-1:0]   i_cfg_data
);

    logic           push, full, pop, nempty;
    utu_pkg::t_job  push_job, pop_job;

    utu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    utu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_job),
        .o_full   (full),
        .i_pop    (pop),
        .o_nempty (nempty),
        .o_data   (pop_job)
    );

    utu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_vld     (nempty),
        .i_job         (pop_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_bad_input   (o_bad_input)
    );

endmodule

FILE: hw/rtl/utu_checker.sv
module utu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  o_out_byte,
    input  logic        o_last_of_run,
    input  logic        o_bad_input
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_last_of_run) && $stable(o_bad_input))
        else $error("output result changed under stall");

    // an error result carries a zero byte
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_input |-> o_out_byte == 8'd0)
        else $error("error result with nonzero byte");

    // an error that is not last is followed by a code unit, never another error
    a_bad_then_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_bad_input && !o_last_of_run
            |=> !(o_out_valid && o_bad_input))
        else $error("two error results for one input byte");

    // reset empties the output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind utf8_to_utf16_transcoder utu_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run),
    .o_bad_input   (o_bad_input)
);
